[rtl/core/assert_macros.svh]
// assertion macros for the checker file
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, suspended while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/mmt_pkg.sv]
// shared types, codes and helpers for the tiled int8 matrix multiply
// no dependencies; imported by every module of the block
package mmt_pkg;

    // width of the accumulated result
    localparam int unsigned ACC_W = 22;

    // request codes carried in the func field
    localparam logic [1:0] FUNC_WR_A = 2'd0;
    localparam logic [1:0] FUNC_WR_B = 2'd1;
    localparam logic [1:0] FUNC_TILE = 2'd2;

    // register indexes (byte address is four times the index)
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;

    // index of the final element of a 4x4 tile
    localparam logic [3:0] EMIT_LAST = 4'd15;

    typedef struct packed {
        logic [1:0]        func;
        logic [5:0]        row_index;
        logic [5:0]        col_index;
        logic signed [7:0] elem_value;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] product_value;
        logic [5:0]              out_row;
        logic [5:0]              out_col;
        logic                    last;
    } t_out_item;

    // raw size registers
    typedef struct packed {
        logic [6:0] rows;
        logic [6:0] inner;
        logic [6:0] cols;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       start;
        logic       step;
        logic       copy;
        logic [3:0] emit_idx;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic tile_ok;
        logic k_last;
        logic pipe_busy;
    } t_dp_sts;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // size in use: clamp to [4, maxv] and round down to a multiple of four
    function automatic logic [8:0] eff_size(input logic [6:0] v, input logic [8:0] maxv);
        logic [8:0] s;
        s = {2'b00, v};
        if (s < 9'd4) begin
            s = 9'd4;
        end
        if (s > maxv) begin
            s = maxv;
        end
        return s & ~9'd3;
    endfunction

endpackage

[rtl/core/mmt_regs.sv]
// size register file behind the apb-style configuration port
// depends on mmt_pkg
module mmt_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output mmt_pkg::t_cfg  o_cfg
);
    import mmt_pkg::*;

    logic [6:0] r_rows;
    logic [6:0] r_inner;
    logic [6:0] r_cols;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= 7'd64;
            r_inner <= 7'd64;
            r_cols  <= 7'd64;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_ROWS:  r_rows  <= pwdata[6:0];
                REG_INNER: r_inner <= pwdata[6:0];
                REG_COLS:  r_cols  <= pwdata[6:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[3:2])
            REG_ROWS:  prdata = {25'd0, r_rows};
            REG_INNER: prdata = {25'd0, r_inner};
            REG_COLS:  prdata = {25'd0, r_cols};
            default:   prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{rows: r_rows, inner: r_inner, cols: r_cols};

endmodule

[rtl/core/mmt_ctrl.sv]
// control fsm: request handshake, inner-loop sequencing and result streaming
// depends on mmt_pkg
module mmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  mmt_pkg::t_dp_sts  i_sts,
    output mmt_pkg::t_ctl_cmd o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);
    import mmt_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic       r_emit_busy;
    logic [3:0] r_emit_cnt;
    logic       w_accept;
    logic       w_copy;
    logic       w_out_take;

    // command outputs
    always_comb begin
        w_accept = 1'b0;
        w_copy   = 1'b0;
        case (r_state)
            ST_IDLE:  w_accept = i_in_valid;
            ST_DRAIN: w_copy   = !i_sts.pipe_busy && !r_emit_busy;
            default:  ;
        endcase
        o_cmd.accept   = w_accept;
        o_cmd.start    = w_accept && i_sts.tile_ok;
        o_cmd.step     = (r_state == ST_RUN);
        o_cmd.copy     = w_copy;
        o_cmd.emit_idx = r_emit_cnt;
        o_in_stall     = (r_state != ST_IDLE);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.tile_ok) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_sts.k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy && !r_emit_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result streaming: sixteen transactions per tile from the result bank
    assign o_out_valid = r_emit_busy;
    assign w_out_take  = r_emit_busy && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_busy <= 1'b0;
            r_emit_cnt  <= 4'd0;
        end else if (w_copy) begin
            r_emit_busy <= 1'b1;
            r_emit_cnt  <= 4'd0;
        end else if (w_out_take) begin
            if (r_emit_cnt == EMIT_LAST) begin
                r_emit_busy <= 1'b0;
            end
            r_emit_cnt <= r_emit_cnt + 4'd1;
        end
    end

endmodule

[rtl/core/mmt_dpath.sv]
// datapath: banked element stores, 16 mac lanes and the result bank
// depends on mmt_pkg
module mmt_dpath #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmt_pkg::t_cfg     i_cfg,
    input  mmt_pkg::t_in_item i_in_data,
    input  mmt_pkg::t_ctl_cmd i_cmd,
    output mmt_pkg::t_dp_sts  o_sts,
    output mmt_pkg::t_out_item o_out_data
);
    import mmt_pkg::*;

    // four banks per store: A split by row mod 4, B by column mod 4
    localparam int ROWS_Q  = (MAX_ROWS + 3) / 4;
    localparam int COLS_Q  = (MAX_COLS + 3) / 4;
    localparam int A_DEPTH = ROWS_Q * MAX_INNER;
    localparam int B_DEPTH = COLS_Q * MAX_INNER;
    localparam int AAW     = $clog2(A_DEPTH);
    localparam int BAW     = $clog2(B_DEPTH);
    localparam int KW      = $clog2(MAX_INNER);

    logic [8:0]       w_nr;
    logic [8:0]       w_nk;
    logic [8:0]       w_nc;
    logic             w_a_ok;
    logic             w_b_ok;
    logic [3:0]       w_a_we;
    logic [3:0]       w_b_we;
    logic [3:0]       w_a_row_q;
    logic [8:0]       w_a_k;
    logic [8:0]       w_b_k;
    logic [3:0]       w_b_col_q;
    logic [AAW-1:0]   w_a_addr;
    logic [BAW-1:0]   w_b_addr;

    logic [3:0]       r_top_q;
    logic [3:0]       r_left_q;
    logic [3:0]       r_emit_top_q;
    logic [3:0]       r_emit_left_q;
    logic [KW-1:0]    r_k;
    logic             r_v1;
    logic             r_v2;
    logic [7:0]       r_a_rd [4];
    logic [7:0]       r_b_rd [4];
    logic signed [15:0] r_prod [4][4];
    logic [ACC_W-1:0] r_acc [4][4];
    logic [ACC_W-1:0] r_res [16];

    // sizes in use
    assign w_nr = eff_size(i_cfg.rows,  9'(MAX_ROWS));
    assign w_nk = eff_size(i_cfg.inner, 9'(MAX_INNER));
    assign w_nc = eff_size(i_cfg.cols,  9'(MAX_COLS));

    // request decode
    assign w_a_ok = ({3'd0, i_in_data.row_index} < w_nr) && ({3'd0, i_in_data.col_index} < w_nk);
    assign w_b_ok = ({3'd0, i_in_data.row_index} < w_nk) && ({3'd0, i_in_data.col_index} < w_nc);

    assign o_sts.tile_ok = (i_in_data.func == FUNC_TILE)
        && ({3'd0, i_in_data.row_index[5:2], 2'b00} + 9'd4 <= w_nr)
        && ({3'd0, i_in_data.col_index[5:2], 2'b00} + 9'd4 <= w_nc);
    assign o_sts.k_last    = (r_k == KW'(w_nk - 9'd1));
    assign o_sts.pipe_busy = r_v1 || r_v2;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_a_we[j] = i_cmd.accept && (i_in_data.func == FUNC_WR_A) && w_a_ok
                && (i_in_data.row_index[1:0] == 2'(j));
            w_b_we[j] = i_cmd.accept && (i_in_data.func == FUNC_WR_B) && w_b_ok
                && (i_in_data.col_index[1:0] == 2'(j));
        end
    end

    // store addresses: element write, or inner-loop read for the current tile
    assign w_a_row_q = i_cmd.step ? r_top_q  : i_in_data.row_index[5:2];
    assign w_a_k     = i_cmd.step ? 9'(r_k)  : 9'(i_in_data.col_index);
    assign w_b_k     = i_cmd.step ? 9'(r_k)  : 9'(i_in_data.row_index);
    assign w_b_col_q = i_cmd.step ? r_left_q : i_in_data.col_index[5:2];
    assign w_a_addr  = AAW'(32'(w_a_row_q) * MAX_INNER + 32'(w_a_k));
    assign w_b_addr  = BAW'(32'(w_b_k) * COLS_Q + 32'(w_b_col_q));

    // store banks, one read per bank per cycle and at most one write, at the same address
    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic [7:0] r_a_mem [A_DEPTH];
        logic [7:0] r_b_mem [B_DEPTH];

        always_ff @(posedge i_clk) begin
            if (w_a_we[j]) begin
                r_a_mem[w_a_addr] <= i_in_data.elem_value;
            end
            r_a_rd[j] <= r_a_mem[w_a_addr];
        end

        always_ff @(posedge i_clk) begin
            if (w_b_we[j]) begin
                r_b_mem[w_b_addr] <= i_in_data.elem_value;
            end
            r_b_rd[j] <= r_b_mem[w_b_addr];
        end
    end

    // tile origin and inner index
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_top_q  <= i_in_data.row_index[5:2];
            r_left_q <= i_in_data.col_index[5:2];
            r_k      <= '0;
        end else if (i_cmd.step) begin
            r_k <= r_k + KW'(1);
        end
    end

    // read and multiply stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
        end
    end

    // 16 signed products
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[r][c] <= $signed(r_a_rd[r]) * $signed(r_b_rd[c]);
                end
            end
        end
    end

    // accumulate, wrapping at the result width
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (i_cmd.start) begin
                    r_acc[r][c] <= '0;
                end else if (r_v2) begin
                    r_acc[r][c] <= r_acc[r][c]
                        + {{(ACC_W-16){r_prod[r][c][15]}}, r_prod[r][c]};
                end
            end
        end
    end

    // hand finished sums to the result bank so the next tile can start
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy) begin
            r_emit_top_q  <= r_top_q;
            r_emit_left_q <= r_left_q;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_res[4'(r * 4 + c)] <= r_acc[r][c];
                end
            end
        end
    end

    // result transaction payload, row-major
    assign o_out_data.product_value = r_res[i_cmd.emit_idx];
    assign o_out_data.out_row       = {r_emit_top_q,  i_cmd.emit_idx[3:2]};
    assign o_out_data.out_col       = {r_emit_left_q, i_cmd.emit_idx[1:0]};
    assign o_out_data.last          = (i_cmd.emit_idx == EMIT_LAST);

endmodule

[rtl/core/int8_matrix_multiply_tiled.sv]
// top level of the tiled int8 matrix multiply with 22-bit result sums
// depends on mmt_pkg, mmt_regs, mmt_ctrl and mmt_dpath
//
// Element writes (func 0 for A, 1 for B) are taken while idle. A tile request
// (func 2) is taken while idle and then holds the input side until its sums are
// in the result bank: the inner loop reads one column of A and one row of B per
// cycle from four banks per store and feeds sixteen 8x8 multiply-accumulate
// lanes, then the read and multiply stages drain and the sums move to a result bank.
// The sixteen results then stream out one per cycle while the output is not stalled,
// and new requests are taken meanwhile; a following tile waits at its end only if
// the previous sixteen are not yet gone.
// Store entries are undefined until written and need no clearing after reset.
module int8_matrix_multiply_tiled #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mmt_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mmt_pkg::t_out_item  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mmt_pkg::*;

    t_cfg     w_cfg;
    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;

    // configuration registers
    mmt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // controller
    mmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // datapath
    mmt_dpath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

[rtl/core/mmt_checker.sv]
// port-level checks on the result stream of the tiled matrix multiply
// depends on mmt_pkg and assert_macros.svh; bound to int8_matrix_multiply_tiled
module mmt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input mmt_pkg::t_out_item i_out_data
);
    import mmt_pkg::*;
`include "assert_macros.svh"

    logic w_take;
    assign w_take = i_out_valid && !i_out_stall;

    // stalled result transaction stays offered and unchanged
    `ASSERT_CLK(a_valid_hold, (i_out_valid && i_out_stall) |=> i_out_valid, "result valid dropped while stalled")
    `ASSERT_CLK(a_data_hold, (i_out_valid && i_out_stall) |=> $stable(i_out_data), "result payload changed while stalled")

    // within a tile results follow back to back, columns stepping row-major
    `ASSERT_CLK(a_tile_cont, (w_take && !i_out_data.last) |=> i_out_valid, "gap inside a tile")
    `ASSERT_CLK(a_col_step, (w_take && !i_out_data.last) |=> (i_out_data.out_col[1:0] == $past(i_out_data.out_col[1:0]) + 2'd1), "tile column out of order")

    // nothing is offered right after reset
    `ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind int8_matrix_multiply_tiled mmt_checker u_mmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
